### rtl/pdl_pkg.sv
// Shared types and constants for the password door lock controller.
// No dependencies; imported by every module in this folder.
package pdl_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SEC_W  = 8;
  localparam int unsigned ATT_W  = 3;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [BYTE_W-1:0] CMD_SETUP = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h2D;  // '-'

  localparam logic [SEC_W-1:0] SEC_MAX = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_END    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_END    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_END   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_END = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATT     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [SEC_W-1:0] OPEN_END_RST    = 8'd15;
  localparam logic [SEC_W-1:0] HOLD_END_RST    = 8'd18;
  localparam logic [SEC_W-1:0] CLOSE_END_RST   = 8'd33;
  localparam logic [SEC_W-1:0] LOCKOUT_END_RST = 8'd60;
  localparam logic [ATT_W-1:0] MAX_ATT_RST     = 3'd3;

  // Item kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Motor drive codes
  localparam logic [1:0] MOTOR_OFF = 2'd0;
  localparam logic [1:0] MOTOR_CW  = 2'd1;
  localparam logic [1:0] MOTOR_ACW = 2'd2;

  typedef enum logic [5:0] {
    MODE_SETUP_FIRST   = 6'b000001,
    MODE_SETUP_CONFIRM = 6'b000010,
    MODE_IDLE          = 6'b000100,
    MODE_ENTRY         = 6'b001000,
    MODE_DOOR          = 6'b010000,
    MODE_ALARM         = 6'b100000
  } pdl_mode_t;

  typedef struct packed {
    logic [SEC_W-1:0] open_end;
    logic [SEC_W-1:0] hold_end;
    logic [SEC_W-1:0] close_end;
    logic [SEC_W-1:0] lockout_end;
    logic [ATT_W-1:0] max_attempts;
  } pdl_cfg_t;

  typedef struct packed {
    logic       reply_valid;
    logic       reply_match;
    logic [1:0] motor_drive;
    logic       buzzer_on;
  } pdl_result_t;

endpackage

### rtl/pdl_core.sv
// Lock state, code stores and per-item update of the door lock controller.
// Depends on pdl_pkg.
module pdl_core
  import pdl_pkg::*;
#(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              req_type,
  input  logic [BYTE_W-1:0] rx_byte,
  input  pdl_cfg_t          cfg,
  output pdl_result_t       result
);

  localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CODE_LENGTH - 1);

  pdl_mode_t         mode, mode_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic              mismatch_seen, mismatch_seen_next;
  logic [ATT_W-1:0]  attempt_count, attempt_count_next;
  logic [SEC_W-1:0]  second_count, second_count_next;

  logic [BYTE_W-1:0] first_entry [CODE_LENGTH];
  logic [BYTE_W-1:0] stored_code [CODE_LENGTH];

  logic              wr_first;
  logic              copy_code;
  logic              last_byte;
  logic              diff_first;
  logic              diff_stored;
  logic              mis_cur;
  logic [ATT_W-1:0]  att_inc;
  logic [SEC_W-1:0]  sec_inc;
  logic              rv;
  logic              rm;
  logic [1:0]        drive;

  assign last_byte   = (byte_index == IDX_LAST);
  assign diff_first  = (first_entry[byte_index] != rx_byte);
  assign diff_stored = (stored_code[byte_index] != rx_byte);
  assign att_inc     = attempt_count + ATT_W'(1);
  assign sec_inc     = (second_count == SEC_MAX) ? second_count : second_count + SEC_W'(1);

  always_comb begin
    mode_next          = mode;
    byte_index_next    = byte_index;
    mismatch_seen_next = mismatch_seen;
    attempt_count_next = attempt_count;
    second_count_next  = second_count;
    wr_first           = 1'b0;
    copy_code          = 1'b0;
    mis_cur            = 1'b0;
    rv                 = 1'b0;
    rm                 = 1'b0;
    if (fire) begin
      if (req_type == REQ_TICK) begin
        if (mode == MODE_DOOR || mode == MODE_ALARM) begin
          second_count_next = sec_inc;
          if (mode == MODE_DOOR && sec_inc > cfg.close_end) begin
            mode_next = MODE_IDLE;
          end else if (mode == MODE_ALARM && sec_inc > cfg.lockout_end) begin
            mode_next = MODE_IDLE;
          end
        end
      end else begin
        case (mode)
          MODE_SETUP_FIRST: begin
            wr_first = 1'b1;
            if (last_byte) begin
              mode_next          = MODE_SETUP_CONFIRM;
              byte_index_next    = '0;
              mismatch_seen_next = 1'b0;
            end else begin
              byte_index_next = byte_index + IDX_W'(1);
            end
          end
          MODE_SETUP_CONFIRM: begin
            mis_cur = mismatch_seen | diff_first;
            if (last_byte) begin
              rv                 = 1'b1;
              rm                 = ~mis_cur;
              byte_index_next    = '0;
              mismatch_seen_next = 1'b0;
              if (mis_cur) begin
                mode_next = MODE_SETUP_FIRST;
              end else begin
                copy_code = 1'b1;
                mode_next = MODE_IDLE;
              end
            end else begin
              byte_index_next    = byte_index + IDX_W'(1);
              mismatch_seen_next = mis_cur;
            end
          end
          MODE_IDLE: begin
            if (rx_byte == CMD_SETUP) begin
              mode_next          = MODE_SETUP_FIRST;
              byte_index_next    = '0;
              mismatch_seen_next = 1'b0;
            end else if (rx_byte == CMD_OPEN) begin
              mode_next          = MODE_ENTRY;
              attempt_count_next = '0;
              byte_index_next    = '0;
              mismatch_seen_next = 1'b0;
            end
          end
          MODE_ENTRY: begin
            mis_cur = mismatch_seen | diff_stored;
            if (last_byte) begin
              rv              = 1'b1;
              rm              = ~mis_cur;
              byte_index_next = '0;
              if (!mis_cur) begin
                second_count_next = '0;
                mode_next         = MODE_DOOR;
              end else begin
                mismatch_seen_next = 1'b0;
                attempt_count_next = att_inc;
                // a zero limit behaves as one attempt
                if (att_inc >= cfg.max_attempts || att_inc == '0) begin
                  second_count_next = '0;
                  mode_next         = MODE_ALARM;
                end
              end
            end else begin
              byte_index_next    = byte_index + IDX_W'(1);
              mismatch_seen_next = mis_cur;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Phases are tested in order: a phase ending below an earlier one is skipped
  always_comb begin
    drive = MOTOR_OFF;
    if (mode_next == MODE_DOOR) begin
      if (second_count_next <= cfg.open_end) begin
        drive = MOTOR_CW;
      end else if (second_count_next <= cfg.hold_end) begin
        drive = MOTOR_OFF;
      end else if (second_count_next <= cfg.close_end) begin
        drive = MOTOR_ACW;
      end
    end
  end

  assign result.reply_valid = rv;
  assign result.reply_match = rm;
  assign result.motor_drive = drive;
  assign result.buzzer_on   = (mode_next == MODE_ALARM);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SETUP_FIRST;
      byte_index    <= '0;
      mismatch_seen <= 1'b0;
      attempt_count <= '0;
      second_count  <= '0;
    end else begin
      mode          <= mode_next;
      byte_index    <= byte_index_next;
      mismatch_seen <= mismatch_seen_next;
      attempt_count <= attempt_count_next;
      second_count  <= second_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_entry[byte_index] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (copy_code) begin
      stored_code <= first_entry;
    end
  end

endmodule

### rtl/pdl_out_buf.sv
// Two-entry result buffer between the lock core and the output channel.
// Depends on pdl_pkg.
module pdl_out_buf
  import pdl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pdl_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output pdl_result_t out_data
);

  pdl_result_t entry [2];
  logic        wr_ptr, wr_ptr_next;
  logic        rd_ptr, rd_ptr_next;
  logic [1:0]  count, count_next;
  logic        pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid & ~out_stall;
  assign out_data  = entry[rd_ptr];

  always_comb begin
    wr_ptr_next = push ? ~wr_ptr : wr_ptr;
    rd_ptr_next = pop ? ~rd_ptr : rd_ptr;
    count_next  = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/password_door_lock_controller_top.sv
// Password door lock controller, top level: input register, configuration
// registers, lock core and result buffer. Depends on pdl_pkg, pdl_core, pdl_out_buf.
//
// Each input transaction is a received byte or a one-second tick, and each one
// yields exactly one result transaction carrying the code-check reply and the
// motor and buzzer state after that item. The block takes one transaction per
// clock cycle for as long as the output side keeps up; a taken input passes
// through the input register to the core, whose update is written into the
// two-entry result buffer, from which its result is offered. The buffer lets
// the input keep flowing while one finished result waits; the input stalls
// only when both buffer entries are held and the input register is occupied.
// After reset the block expects the new code and its confirmation before
// anything else; ticks are counted only during the door sequence and the
// lockout, and bytes arriving then are dropped.
// Configuration writes are always ready and must be made only while no
// transaction is in flight.
module password_door_lock_controller_top
  import pdl_pkg::*;
#(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [BYTE_W-1:0]      rx_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   reply_valid,
  output logic                   reply_match,
  output logic [1:0]             motor_drive,
  output logic                   buzzer_on,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SEC_W-1:0]       cfg_data
);

  logic              in_reg_valid, in_reg_valid_next;
  logic              in_reg_req;
  logic [BYTE_W-1:0] in_reg_byte;
  logic              in_accept;
  logic              fire;
  logic              buf_full;
  pdl_cfg_t          cfg;
  pdl_result_t       core_result;
  pdl_result_t       out_data;

  // Hold the registered item while the buffer is full; advance otherwise
  assign fire      = in_reg_valid & ~buf_full;
  assign in_stall  = in_reg_valid & buf_full;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    if (in_accept) begin
      in_reg_valid_next = 1'b1;
    end else if (fire) begin
      in_reg_valid_next = 1'b0;
    end else begin
      in_reg_valid_next = in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else begin
      in_reg_valid <= in_reg_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_req  <= req_type;
      in_reg_byte <= rx_byte;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_end     <= OPEN_END_RST;
      cfg.hold_end     <= HOLD_END_RST;
      cfg.close_end    <= CLOSE_END_RST;
      cfg.lockout_end  <= LOCKOUT_END_RST;
      cfg.max_attempts <= MAX_ATT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OPEN_END:    cfg.open_end     <= cfg_data;
        REG_HOLD_END:    cfg.hold_end     <= cfg_data;
        REG_CLOSE_END:   cfg.close_end    <= cfg_data;
        REG_LOCKOUT_END: cfg.lockout_end  <= cfg_data;
        REG_MAX_ATT:     cfg.max_attempts <= cfg_data[ATT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pdl_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .req_type (in_reg_req),
    .rx_byte  (in_reg_byte),
    .cfg      (cfg),
    .result   (core_result)
  );

  pdl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign reply_valid = out_data.reply_valid;
  assign reply_match = out_data.reply_match;
  assign motor_drive = out_data.motor_drive;
  assign buzzer_on   = out_data.buzzer_on;

endmodule
